@@ rtl/lcgp_pkg.sv @@
// Shared types and constants of the LRU key-value cache.
package lcgp_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    localparam int            CFG_BITS  = 5;
    localparam logic [4:0]    CAP_RESET = 5'd16;
    localparam int            READ_BITS = 32;

    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TAIL,
        ST_RESOLVE,
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture the accepted transaction
        logic scan;       // issue a key read at the scan index
        logic resolve;    // apply the lookup outcome to the stores
        logic out_load;   // move the result into the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_last;  // the scan index points at the last entry
    } t_stat;

endpackage

@@ rtl/lcgp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lcgp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/lcgp_ctrl.sv @@
// Sequencing state machine of the LRU cache: accept, scan, resolve, deliver.
module lcgp_ctrl
    import lcgp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_stat.scan_last) begin
                    n_state = ST_TAIL;
                end
            end
            ST_TAIL:    n_state = ST_RESOLVE;
            ST_RESOLVE: n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_SCAN:    o_cmd.scan     = 1'b1;
            ST_TAIL:    o_cmd          = '0;
            ST_RESOLVE: o_cmd.resolve  = 1'b1;
            ST_DONE:    o_cmd.out_load = out_free;
            default:    o_cmd          = '0;
        endcase
    end

    always_comb begin
        priority if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/lcgp_dpath.sv @@
// Datapath of the LRU cache: key/value stores, recency ranks, scan and result.
module lcgp_dpath
    import lcgp_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic                  i_cfg_we,
    input  logic [CFG_BITS-1:0]   i_cfg_wdata,
    input  logic                  i_action,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic                  o_hit,
    output logic [READ_BITS-1:0]  o_read_value,
    output logic                  o_evicted
);

    localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FW   = $clog2(ENTRIES + 1);
    localparam int CMPW = ((FW > CFG_BITS) ? FW : CFG_BITS) + 1;

    // transaction and scan state
    logic                  r_put;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;
    logic [IW-1:0]         r_idx, n_idx;
    logic                  r_cmp_vld;
    logic [IW-1:0]         r_cmp_idx;
    logic                  r_found, n_found;
    logic [IW-1:0]         r_fidx, n_fidx;
    logic                  r_free_f, n_free_f;
    logic [IW-1:0]         r_free_idx, n_free_idx;
    logic [IW-1:0]         r_vict_idx, n_vict_idx;
    logic                  r_ev, n_ev;

    // cache state
    logic                  r_valid [ENTRIES];
    logic                  n_valid [ENTRIES];
    logic [IW-1:0]         r_rank  [ENTRIES];
    logic [IW-1:0]         n_rank  [ENTRIES];
    logic [FW-1:0]         r_fill, n_fill;
    logic [CFG_BITS-1:0]   r_capacity;

    // output register
    logic                  r_o_hit;
    logic [READ_BITS-1:0]  r_o_rv;
    logic                  r_o_ev;

    logic [KEY_BITS-1:0]   key_rdata;
    logic [VALUE_BITS-1:0] val_rdata;
    logic [FW-1:0]         fill_m1;
    logic [CMPW-1:0]       cap_ext, cap_use;
    logic                  fill_ok;

    logic                  key_we, val_we, val_re;
    logic [IW-1:0]         wr_addr;

    logic                  t_en, t_all;
    logic [IW-1:0]         t_idx, t_limit;

    assign fill_m1 = r_fill - 1'b1;
    assign cap_ext = CMPW'(r_capacity);

    always_comb begin
        priority if (cap_ext == '0) begin
            cap_use = CMPW'(1);
        end else if (cap_ext > CMPW'(ENTRIES)) begin
            cap_use = CMPW'(ENTRIES);
        end else begin
            cap_use = cap_ext;
        end
    end

    assign fill_ok = r_free_f && (CMPW'(r_fill) < cap_use);

    // store write port and touch selection for the resolve step
    always_comb begin
        key_we  = 1'b0;
        val_we  = 1'b0;
        val_re  = 1'b0;
        wr_addr = r_fidx;
        t_en    = 1'b0;
        t_all   = 1'b0;
        t_idx   = r_fidx;
        t_limit = r_rank[r_fidx];
        if (i_cmd.resolve) begin
            priority if (r_found) begin
                t_en   = 1'b1;
                val_we = r_put;
                val_re = !r_put;
            end else if (r_put && fill_ok) begin
                key_we  = 1'b1;
                val_we  = 1'b1;
                wr_addr = r_free_idx;
                t_en    = 1'b1;
                t_all   = 1'b1;
                t_idx   = r_free_idx;
            end else if (r_put) begin
                key_we  = 1'b1;
                val_we  = 1'b1;
                wr_addr = r_vict_idx;
                t_en    = 1'b1;
                t_idx   = r_vict_idx;
                t_limit = IW'(fill_m1);
            end else begin
                t_en = 1'b0;
            end
        end
    end

    always_comb begin
        n_idx      = r_idx;
        n_found    = r_found;
        n_fidx     = r_fidx;
        n_free_f   = r_free_f;
        n_free_idx = r_free_idx;
        n_vict_idx = r_vict_idx;
        n_ev       = r_ev;
        n_fill     = r_fill;
        for (int i = 0; i < ENTRIES; i++) begin
            n_valid[i] = r_valid[i];
            n_rank[i]  = r_rank[i];
        end

        if (i_cmd.load) begin
            n_idx    = '0;
            n_found  = 1'b0;
            n_free_f = 1'b0;
            n_ev     = 1'b0;
        end
        if (i_cmd.scan) begin
            n_idx = r_idx + 1'b1;
        end

        // compare the entry read in the previous cycle
        if (r_cmp_vld) begin
            if (r_valid[r_cmp_idx] && (key_rdata == r_key) && !r_found) begin
                n_found = 1'b1;
                n_fidx  = r_cmp_idx;
            end
            if (!r_valid[r_cmp_idx] && !r_free_f) begin
                n_free_f   = 1'b1;
                n_free_idx = r_cmp_idx;
            end
            if (r_valid[r_cmp_idx] && (r_rank[r_cmp_idx] == IW'(fill_m1))) begin
                n_vict_idx = r_cmp_idx;
            end
        end

        if (i_cmd.resolve && !r_found && r_put) begin
            if (fill_ok) begin
                n_valid[r_free_idx] = 1'b1;
                n_fill              = r_fill + 1'b1;
            end else begin
                n_ev = 1'b1;
            end
        end

        // age the valid entries more recent than the limit (all valid ones on a fill), make the target newest
        if (t_en) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (IW'(i) == t_idx) begin
                    n_rank[i] = '0;
                end else if (r_valid[i] && (t_all || (r_rank[i] < t_limit))) begin
                    n_rank[i] = r_rank[i] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_cmp_vld  <= 1'b0;
            r_found    <= 1'b0;
            r_free_f   <= 1'b0;
            r_ev       <= 1'b0;
            r_fill     <= '0;
            r_capacity <= CAP_RESET;
            for (int i = 0; i < ENTRIES; i++) begin
                r_valid[i] <= 1'b0;
                r_rank[i]  <= '0;
            end
        end else begin
            r_idx     <= n_idx;
            r_cmp_vld <= i_cmd.scan;
            r_found   <= n_found;
            r_free_f  <= n_free_f;
            r_ev      <= n_ev;
            r_fill    <= n_fill;
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
            for (int i = 0; i < ENTRIES; i++) begin
                r_valid[i] <= n_valid[i];
                r_rank[i]  <= n_rank[i];
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_cmp_idx  <= r_idx;
        r_fidx     <= n_fidx;
        r_free_idx <= n_free_idx;
        r_vict_idx <= n_vict_idx;
        if (i_cmd.load) begin
            r_put   <= (i_action == ACT_PUT);
            r_key   <= i_key;
            r_value <= i_value;
        end
        if (i_cmd.out_load) begin
            r_o_hit <= r_found;
            r_o_rv  <= (r_found && !r_put) ? READ_BITS'(val_rdata) : '0;
            r_o_ev  <= r_ev;
        end
    end

    lcgp_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (ENTRIES)
    ) u_key_ram (
        .i_clk     (i_clk),
        .i_wr_en   (key_we),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_key),
        .i_rd_en   (i_cmd.scan),
        .i_rd_addr (r_idx),
        .o_rd_data (key_rdata)
    );

    lcgp_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (ENTRIES)
    ) u_val_ram (
        .i_clk     (i_clk),
        .i_wr_en   (val_we),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_value),
        .i_rd_en   (val_re),
        .i_rd_addr (r_fidx),
        .o_rd_data (val_rdata)
    );

    assign o_stat.scan_last = (r_idx == IW'(ENTRIES - 1));
    assign o_hit            = r_o_hit;
    assign o_read_value     = r_o_rv;
    assign o_evicted        = r_o_ev;

endmodule

@@ rtl/lru_cache_get_put.sv @@
// Top level of the fully associative key-value cache with LRU replacement.
//
// Each input transaction is a get (i_action = 0) or a put (i_action = 1) on a
// key. A get that hits returns the stored value on o_read_value and makes the
// entry the most recent; a miss returns o_hit = 0 and a zero value. A put that
// hits refreshes the entry and replaces its value; a put that misses takes a
// free entry while fewer than the configured capacity are in use (clamped to
// 1..ENTRIES), and otherwise overwrites the least recent entry and raises
// o_evicted. Capacity is written through i_cfg_we / i_cfg_wdata; the user
// must do so only while the block is idle, as the block does not enforce it.
// Lowering it below the current fill drops nothing. Keys and values live in
// two single-port-write RAMs, so a lookup is a scan that reads one stored key
// per cycle; valid bits and recency ranks are flip-flops that reset clears, so
// no clearing pass is needed. One transaction is handled at a time; a result
// waits in the output register while the next transaction is accepted and
// scanned.
module lru_cache_get_put
    import lcgp_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_BITS-1:0]   i_cfg_wdata,
    // request channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_action,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [VALUE_BITS-1:0] i_value,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_hit,
    output logic [READ_BITS-1:0]  o_read_value,
    output logic                  o_evicted
);

    t_cmd  cmd;
    t_stat stat;

    // sequence each transaction: accept, scan the keys, resolve, deliver
    lcgp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // hold the stores, ranks and the output register
    lcgp_dpath #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_action     (i_action),
        .i_key        (i_key),
        .i_value      (i_value),
        .o_hit        (o_hit),
        .o_read_value (o_read_value),
        .o_evicted    (o_evicted)
    );

endmodule
